@@ hw/rtl/lspb_pkg.sv @@
// Shared types and constants for the LED strip pixel buffer.
package lspb_pkg;

  // Command codes on in_command
  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_FILL = 2'd1,
    CMD_SHOW = 2'd2,
    CMD_LOAD = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STRIP_LENGTH = 3'd0,
    REG_BRIGHTNESS   = 3'd1,
    REG_SLOT0        = 3'd2,
    REG_SLOT1        = 3'd3,
    REG_SLOT2        = 3'd4,
    REG_SLOT3        = 3'd5
  } reg_idx_t;

  // Slot channel selector codes
  localparam logic [2:0] CH_NONE  = 3'd0;
  localparam logic [2:0] CH_RED   = 3'd1;
  localparam logic [2:0] CH_GREEN = 3'd2;
  localparam logic [2:0] CH_BLUE  = 3'd3;
  localparam logic [2:0] CH_WHITE = 3'd4;

  localparam int NUM_SLOTS  = 4;
  localparam int DIV_STEPS  = 8;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV_LVL,
    ST_LOAD_CH,
    ST_DIV_CH,
    ST_WRITE,
    ST_SHOW
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic div_load_lvl;
    logic div_load_ch;
    logic div_step;
    logic clear_wr;
    logic mem_wr;
    logic mem_rd;
    logic cnt_inc;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_lt_end;
    logic cnt_lt_len;
    logic clear_done;
  } sts_t;

endpackage

@@ hw/rtl/led_strip_pixel_buffer_core.sv @@
// LED strip pixel buffer: remaps and scales colors, stores pixels, streams them on show.
// Load raw word: one store write of in_color. Set pixel: two 8-step divider passes
// (255/level, then channel/divisor), one operand load and one store write. Fill: the same
// passes, then one store write per cycle for n pixels. Show: streams len words; each word
// is read from the store into a register before it is on the ports, one beat per cycle, the
// single store read port sets the pace. The receiver cannot stall. After reset the store is
// cleared one word per cycle, and the block is busy until the clearing pass ends.
module led_strip_pixel_buffer_core #(
  parameter int MAX_PIXELS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [5:0]  in_pixel_index,
  input  logic [31:0] in_color,
  input  logic [6:0]  in_fill_count,
  output logic        out_valid,
  output logic [31:0] out_strip_word,
  output logic        out_last_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  lspb_pkg::ctl_t ctl;
  lspb_pkg::sts_t sts;

  lspb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  lspb_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_command     (in_command),
    .in_pixel_index (in_pixel_index),
    .in_color       (in_color),
    .in_fill_count  (in_fill_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_strip_word (out_strip_word),
    .out_last_word  (out_last_word)
  );

  // Every accepted command makes the block busy right after accept
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block idle right after accepting a command");

  // A beat only follows a store read issued while busy
  a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("output beat without a show in progress");

  // The last flag only rides on a beat
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> out_valid)
    else $error("last flag without a beat");

  // The clearing pass holds the block busy right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> busy)
    else $error("block not busy during the clearing pass");

endmodule

@@ hw/rtl/lspb_div_lane.sv @@
// One restoring divider lane, 8-bit by 8-bit, one quotient bit per cycle while step is high.
module lspb_div_lane (
  input  logic       clk,
  input  logic       load,
  input  logic       step,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic [7:0] quotient
);

  logic [7:0] rem_r, rem_nxt;
  logic [7:0] dvd_r, dvd_nxt;
  logic [7:0] dsr_r, dsr_nxt;
  logic [8:0] trial;
  logic [8:0] diff;
  logic       ge;

  // Trial subtract of the next partial remainder
  always_comb begin
    trial = {rem_r, dvd_r[7]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  // Load operands or shift in one quotient bit
  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    if (load) begin
      rem_nxt = 8'd0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
    end else if (step) begin
      rem_nxt = ge ? diff[7:0] : trial[7:0];
      dvd_nxt = {dvd_r[6:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = dvd_r;

endmodule

@@ hw/rtl/lspb_ctrl.sv @@
// Controller state machine: sequences clear, conversion, write and show.
module lspb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [1:0]            in_command,
  input  lspb_pkg::sts_t        sts,
  output lspb_pkg::ctl_t        ctl,
  output logic                  busy
);

  lspb_pkg::state_t state_r, state_nxt;
  logic [2:0]       step_r, step_nxt;
  logic             accept;
  logic             last_step;

  assign accept    = start && (state_r == lspb_pkg::ST_IDLE);
  assign last_step = (step_r == 3'(lspb_pkg::DIV_STEPS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lspb_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = lspb_pkg::ST_IDLE;
      end
      lspb_pkg::ST_IDLE: begin
        if (start) begin
          unique case (lspb_pkg::cmd_t'(in_command))
            lspb_pkg::CMD_SET,
            lspb_pkg::CMD_FILL: state_nxt = lspb_pkg::ST_DIV_LVL;
            lspb_pkg::CMD_SHOW: state_nxt = lspb_pkg::ST_SHOW;
            lspb_pkg::CMD_LOAD: state_nxt = lspb_pkg::ST_WRITE;
          endcase
        end
      end
      lspb_pkg::ST_DIV_LVL: begin
        if (last_step) state_nxt = lspb_pkg::ST_LOAD_CH;
      end
      lspb_pkg::ST_LOAD_CH: state_nxt = lspb_pkg::ST_DIV_CH;
      lspb_pkg::ST_DIV_CH: begin
        if (last_step) state_nxt = lspb_pkg::ST_WRITE;
      end
      lspb_pkg::ST_WRITE: begin
        if (!sts.cnt_lt_end) state_nxt = lspb_pkg::ST_IDLE;
      end
      lspb_pkg::ST_SHOW: begin
        if (!sts.cnt_lt_len) state_nxt = lspb_pkg::ST_IDLE;
      end
    endcase
  end

  // Divider step count; wraps to zero after each phase
  always_comb begin
    step_nxt = step_r;
    if (state_r == lspb_pkg::ST_DIV_LVL || state_r == lspb_pkg::ST_DIV_CH) begin
      step_nxt = step_r + 3'd1;
    end
  end

  // Outputs
  always_comb begin
    ctl = '0;
    unique case (state_r)
      lspb_pkg::ST_CLEAR: begin
        ctl.clear_wr = 1'b1;
        ctl.cnt_inc  = 1'b1;
      end
      lspb_pkg::ST_IDLE: begin
        ctl.accept       = accept;
        ctl.div_load_lvl = accept &&
                           (in_command == lspb_pkg::CMD_SET ||
                            in_command == lspb_pkg::CMD_FILL);
      end
      lspb_pkg::ST_DIV_LVL,
      lspb_pkg::ST_DIV_CH: ctl.div_step = 1'b1;
      lspb_pkg::ST_LOAD_CH: ctl.div_load_ch = 1'b1;
      lspb_pkg::ST_WRITE: begin
        ctl.mem_wr  = sts.cnt_lt_end;
        ctl.cnt_inc = sts.cnt_lt_end;
      end
      lspb_pkg::ST_SHOW: begin
        ctl.mem_rd  = sts.cnt_lt_len;
        ctl.cnt_inc = sts.cnt_lt_len;
      end
    endcase
  end

  assign busy = (state_r != lspb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lspb_pkg::ST_CLEAR;
      step_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

@@ hw/rtl/lspb_dp.sv @@
// Datapath: config registers, color conversion lanes, pixel store and output beat.
module lspb_dp #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lspb_pkg::ctl_t       ctl,
  output lspb_pkg::sts_t       sts,
  input  logic [1:0]           in_command,
  input  logic [5:0]           in_pixel_index,
  input  logic [31:0]          in_color,
  input  logic [6:0]           in_fill_count,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_wdata,
  output logic                 out_valid,
  output logic [31:0]          out_strip_word,
  output logic                 out_last_word
);

  localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CWR = $clog2(MAX_PIXELS + 1);
  localparam int CW  = (CWR > 8) ? CWR : 8;

  // Configuration registers
  logic [6:0] strip_length_r;
  logic [7:0] brightness_r;
  logic [2:0] slot_sel_r [lspb_pkg::NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_length_r <= 7'd64;
      brightness_r   <= 8'd255;
      slot_sel_r[0]  <= lspb_pkg::CH_NONE;
      slot_sel_r[1]  <= lspb_pkg::CH_GREEN;
      slot_sel_r[2]  <= lspb_pkg::CH_RED;
      slot_sel_r[3]  <= lspb_pkg::CH_BLUE;
    end else if (cfg_we) begin
      case (lspb_pkg::reg_idx_t'(cfg_index))
        lspb_pkg::REG_STRIP_LENGTH: strip_length_r <= cfg_wdata[6:0];
        lspb_pkg::REG_BRIGHTNESS:
          brightness_r <= (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
        lspb_pkg::REG_SLOT0: slot_sel_r[0] <= cfg_wdata[2:0];
        lspb_pkg::REG_SLOT1: slot_sel_r[1] <= cfg_wdata[2:0];
        lspb_pkg::REG_SLOT2: slot_sel_r[2] <= cfg_wdata[2:0];
        lspb_pkg::REG_SLOT3: slot_sel_r[3] <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Length in use: strip length clipped to the store depth
  logic [CW-1:0] len;
  assign len = (CW'(strip_length_r) < CW'(MAX_PIXELS)) ? CW'(strip_length_r)
                                                       : CW'(MAX_PIXELS);

  // Latch the command, the color and the clipped range end on accept
  logic [1:0]    cmd_r;
  logic [31:0]   color_r;
  logic [CW-1:0] end_r;
  logic [7:0]    span;
  logic [CW-1:0] range_end;

  always_comb begin
    span      = 8'(in_pixel_index) +
                ((in_command == lspb_pkg::CMD_FILL) ? 8'(in_fill_count) : 8'd1);
    range_end = (CW'(span) > len) ? len : CW'(span);
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r   <= in_command;
      color_r <= in_color;
      end_r   <= range_end;
    end
  end

  // Address counter: start index on accept, zero for show and after reset
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.accept) begin
      cnt_nxt = (in_command == lspb_pkg::CMD_SHOW) ? '0 : CW'(in_pixel_index);
    end else if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign sts.cnt_lt_end = (cnt_r < end_r);
  assign sts.cnt_lt_len = (cnt_r < len);
  assign sts.clear_done = (cnt_r == CW'(MAX_PIXELS - 1));

  // Conversion lanes: first 255/level, then channel/divisor per slot
  logic [7:0] quot     [lspb_pkg::NUM_SLOTS];
  logic [7:0] chan     [lspb_pkg::NUM_SLOTS];
  logic [7:0] dividend [lspb_pkg::NUM_SLOTS];
  logic [7:0] divisor;

  assign divisor = ctl.div_load_lvl ? brightness_r : quot[0];

  for (genvar s = 0; s < lspb_pkg::NUM_SLOTS; s++) begin : g_lane
    // Pick the channel named by this slot's selector
    always_comb begin
      unique case (slot_sel_r[s])
        lspb_pkg::CH_RED:   chan[s] = color_r[7:0];
        lspb_pkg::CH_GREEN: chan[s] = color_r[15:8];
        lspb_pkg::CH_BLUE:  chan[s] = color_r[23:16];
        lspb_pkg::CH_WHITE: chan[s] = color_r[31:24];
        default:            chan[s] = 8'd0;
      endcase
      dividend[s] = ctl.div_load_lvl ? lspb_pkg::FULL_SCALE : chan[s];
    end

    lspb_div_lane u_lane (
      .clk      (clk),
      .load     (ctl.div_load_lvl | ctl.div_load_ch),
      .step     (ctl.div_step),
      .dividend (dividend[s]),
      .divisor  (divisor),
      .quotient (quot[s])
    );
  end

  // Slot 0 lands in the top byte
  logic [31:0] conv_word;
  assign conv_word = {quot[0], quot[1], quot[2], quot[3]};

  // Pixel store: one write or one read port per cycle, registered read
  logic [31:0] store [MAX_PIXELS];
  logic [31:0] wr_data;
  logic        wr_en;

  assign wr_en   = ctl.clear_wr | ctl.mem_wr;
  assign wr_data = ctl.clear_wr ? 32'd0 :
                   (cmd_r == lspb_pkg::CMD_LOAD) ? color_r : conv_word;

  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[cnt_r[AW-1:0]] <= wr_data;
    end
    if (ctl.mem_rd) begin
      rd_data_r <= store[cnt_r[AW-1:0]];
    end
  end

  // Output beat strobe and last flag
  logic out_valid_r;
  logic out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= ctl.mem_rd;
      out_last_r  <= ctl.mem_rd && ((cnt_r + CW'(1)) == len);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_last_word  = out_last_r;
  assign out_strip_word = rd_data_r;

endmodule
